### sv/mips_subset_execute_unit_macros.svh
// assertion macros for the mips subset execute unit
`ifndef MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH
`define MIPS_SUBSET_EXECUTE_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define MSE_ASSERT_IMP(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define MSE_ASSERT_NOW(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`else
`define MSE_ASSERT_IMP(label, clk, rst, prop, msg)
`define MSE_ASSERT_NOW(label, clk, rst, cond, msg)
`endif
`endif

### sv/mse_pkg.sv
// shared types and constants for the mips subset execute unit
package mse_pkg;
   localparam int ProgramDepth = 32768;
   localparam int DataDepth    = 1024;
   localparam int DataAw       = 10;

   localparam logic [1:0] KIND_EXEC  = 2'd0;
   localparam logic [1:0] KIND_LOAD  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   localparam logic [2:0] ST_OK     = 3'd0;
   localparam logic [2:0] ST_END    = 3'd1;
   localparam logic [2:0] ST_EXIT   = 3'd2;
   localparam logic [2:0] ST_TARGET = 3'd3;
   localparam logic [2:0] ST_DATA   = 3'd4;
   localparam logic [2:0] ST_DIV0   = 3'd5;

   localparam logic [5:0] OP_SPECIAL = 6'd0;
   localparam logic [5:0] OP_J       = 6'd2;
   localparam logic [5:0] OP_BEQ     = 6'd4;
   localparam logic [5:0] OP_BNE     = 6'd5;
   localparam logic [5:0] OP_ADDIU   = 6'd9;
   localparam logic [5:0] OP_LW      = 6'd35;
   localparam logic [5:0] OP_SW      = 6'd43;

   localparam logic [5:0] FN_SYSCALL = 6'd12;
   localparam logic [5:0] FN_MFHI    = 6'd16;
   localparam logic [5:0] FN_MFLO    = 6'd18;
   localparam logic [5:0] FN_MULT    = 6'd24;
   localparam logic [5:0] FN_DIV     = 6'd26;
   localparam logic [5:0] FN_ADDU    = 6'd33;
   localparam logic [5:0] FN_SUBU    = 6'd35;
   localparam logic [5:0] FN_AND     = 6'd36;
   localparam logic [5:0] FN_OR      = 6'd37;
   localparam logic [5:0] FN_SLT     = 6'd42;

   localparam logic [1:0] MD_MULT = 2'd0;
   localparam logic [1:0] MD_DIV  = 2'd1;

   localparam logic [4:0] REG_V0 = 5'd2;
   localparam logic [4:0] REG_A0 = 5'd4;
   localparam logic [4:0] REG_GP = 5'd28;

   localparam logic [0:0] CSR_INSTR_COUNT = 1'd0;
   localparam logic [0:0] CSR_DATA_COUNT  = 1'd1;

   typedef struct packed {
      logic        start;
      logic [1:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } md_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] lo;
      logic [31:0] hi;
   } md_rsp_type;
endpackage

### sv/mse_muldiv.sv
// iterative shift-add multiplier and restoring divider, one bit per cycle
module mse_muldiv
   import mse_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);
   logic        busy_ff, busy_in;
   logic [5:0]  count_ff, count_in;
   logic [1:0]  op_ff, op_in;
   logic        neg_q_ff, neg_q_in, neg_r_ff, neg_r_in;
   logic [63:0] acc_ff, acc_in;
   logic [31:0] mq_ff, mq_in;
   logic [31:0] mc_ff, mc_in;
   logic        done_ff, done_in;
   logic [32:0] sum;
   logic [32:0] trial;
   logic [31:0] abs_a, abs_b, q_fix, r_fix;

   assign abs_a = md_req.a[31] ? (32'd0 - md_req.a) : md_req.a;
   assign abs_b = md_req.b[31] ? (32'd0 - md_req.b) : md_req.b;
   assign sum   = {1'b0, acc_ff[63:32]} + {1'b0, mc_ff};
   assign trial = {acc_ff[62:31]} - {1'b0, mc_ff};
   assign q_fix = neg_q_ff ? (32'd0 - acc_ff[31:0]) : acc_ff[31:0];
   assign r_fix = neg_r_ff ? (32'd0 - acc_ff[63:32]) : acc_ff[63:32];

   always_comb begin
      busy_in  = busy_ff;
      count_in = count_ff;
      op_in    = op_ff;
      neg_q_in = neg_q_ff;
      neg_r_in = neg_r_ff;
      acc_in   = acc_ff;
      mq_in    = mq_ff;
      mc_in    = mc_ff;
      done_in  = 1'b0;
      if (md_req.start) begin
         busy_in  = 1'b1;
         count_in = 6'd0;
         op_in    = md_req.op;
         neg_q_in = md_req.a[31] ^ md_req.b[31];
         neg_r_in = md_req.a[31];
         mc_in    = abs_b;
         mq_in    = abs_a;
         acc_in   = (md_req.op == MD_DIV) ? {32'd0, abs_a} : {32'd0, abs_a};
      end else if (busy_ff) begin
         if (count_ff == 6'd32) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            count_in = count_ff + 6'd1;
            if (op_ff == MD_MULT) begin
               // unsigned shift-add on magnitudes, sign applied at the end
               if (acc_ff[0]) acc_in = {sum, acc_ff[31:1]};
               else           acc_in = {1'b0, acc_ff[63:1]};
            end else begin
               if (!trial[32]) acc_in = {trial[31:0], acc_ff[30:0], 1'b1};
               else            acc_in = {acc_ff[62:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= 6'd0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      op_ff    <= op_in;
      neg_q_ff <= neg_q_in;
      neg_r_ff <= neg_r_in;
      acc_ff   <= acc_in;
      mq_ff    <= mq_in;
      mc_ff    <= mc_in;
   end

   always_comb begin
      md_rsp.done = done_ff;
      if (op_ff == MD_MULT) begin
         {md_rsp.hi, md_rsp.lo} = neg_q_ff ? (64'd0 - acc_ff) : acc_ff;
      end else begin
         md_rsp.lo = q_fix;
         md_rsp.hi = r_fix;
      end
   end
endmodule

### sv/mips_subset_execute_unit.sv
// mips subset execute unit top level: sequencer, register file, data memory
//
// channels: req_ beats carry one item (execute, load data word, start program);
// rsp_ beats carry one result per item. csr_ is an apb port with two registers:
// instruction_count at byte 0 and data_count at byte 4, to be written only
// while idle; the unit does not enforce this. an item is taken when idle,
// registers read on accept; an execute item passes the read and execute
// states, then sends its result beat; lw adds a load state for the registered
// memory read. mult and div use the shared one-bit-per-cycle unit. a start item
// sweeps the 32 registers, one per cycle, zeroing all but gp (set to
// instruction_count). reset clears control state, registers, hi/lo, pc and
// halt; data memory is undefined until written. a stalled result stays in the
// output register and no new item is accepted until it is taken.
`include "mips_subset_execute_unit_macros.svh"
module mips_subset_execute_unit
   import mse_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: instruction[31:0], data_address[41:32], data_value[73:42],
   // read_value[105:74], zero fill to 112
   input  logic [111:0] req_tdata,
   // tuser: kind[1:0]
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: status[2:0], next_pc[17:3], reg_written[18], written_reg[23:19],
   // written_value[55:24], print_valid[56], print_value[88:57], zero fill to 96
   output logic [95:0] rsp_tdata,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_EXEC  = 3'd2;
   localparam logic [2:0] S_MD    = 3'd3;
   localparam logic [2:0] S_LOAD  = 3'd4;
   localparam logic [2:0] S_CLEAR = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [15:0] icount_ff;
   logic [10:0] dcount_ff;
   logic [31:0] regs_ff [32];
   logic [31:0] hi_ff, lo_ff;
   logic [14:0] pc_ff, pc_in;
   logic        halted_ff, halted_in;
   logic [31:0] dmem [DataDepth];
   logic [31:0] dmem_q_ff;
   logic [31:0] ins_ff, rv_ff;
   logic [1:0]  kind_ff;
   logic [31:0] vs_ff, vt_ff, v0_ff, a0_ff;
   logic [4:0]  clr_ff;
   logic [2:0]  st_ff, st_in;
   logic [14:0] npc_ff, npc_in;
   logic        wv_ff, wv_in;
   logic [4:0]  wr_ff, wr_in;
   logic [31:0] wval_ff, wval_in;
   logic        pv_ff, pv_in;
   logic [31:0] pval_ff, pval_in;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [31:0] rf_wd;
   logic        dm_we;
   logic [DataAw-1:0] dm_wa;
   logic [31:0] dm_wd;
   logic        hl_we;
   logic [31:0] hi_in, lo_in;
   md_req_type  md_req;
   md_rsp_type  md_rsp;

   logic [5:0]  op, fn;
   logic [4:0]  rs, rt, rd;
   logic [31:0] simm;
   logic [16:0] plen;
   logic [10:0] dlen;
   logic [17:0] target;
   logic        jump;

   assign op   = ins_ff[31:26];
   assign rs   = ins_ff[25:21];
   assign rt   = ins_ff[20:16];
   assign rd   = ins_ff[15:11];
   assign fn   = ins_ff[5:0];
   assign simm = {{16{ins_ff[15]}}, ins_ff[15:0]};
   assign plen = (icount_ff > 16'(ProgramDepth)) ? 17'(ProgramDepth) : {1'b0, icount_ff};
   assign dlen = (dcount_ff > 11'(DataDepth)) ? 11'(DataDepth) : dcount_ff;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {7'd0, pval_ff, pv_ff, wval_ff, wr_ff, wv_ff, npc_ff, st_ff};
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_DATA_COUNT) ? {21'd0, dcount_ff}
                                                        : {16'd0, icount_ff};

   mse_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   always_comb begin
      state_in  = state_ff;
      pc_in     = pc_ff;
      halted_in = halted_ff;
      st_in     = st_ff;
      npc_in    = npc_ff;
      wv_in     = wv_ff;
      wr_in     = wr_ff;
      wval_in   = wval_ff;
      pv_in     = pv_ff;
      pval_in   = pval_ff;
      rf_we     = 1'b0;
      rf_wa     = 5'd0;
      rf_wd     = 32'd0;
      dm_we     = 1'b0;
      dm_wa     = ins_ff[DataAw-1:0];
      dm_wd     = vt_ff;
      hl_we     = 1'b0;
      hi_in     = md_rsp.hi;
      lo_in     = md_rsp.lo;
      md_req.start = 1'b0;
      md_req.op    = (fn == FN_DIV) ? MD_DIV : MD_MULT;
      md_req.a     = vs_ff;
      md_req.b     = vt_ff;
      jump      = 1'b0;
      target    = 18'd0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_READ;
         end
         S_READ: begin
            st_in   = ST_OK;
            npc_in  = pc_ff;
            wv_in   = 1'b0;
            wr_in   = 5'd0;
            wval_in = 32'd0;
            pv_in   = 1'b0;
            pval_in = 32'd0;
            state_in = S_OUT;
            case (kind_ff)
               KIND_LOAD: begin
                  dm_we = 1'b1;
                  dm_wa = rv_ff[DataAw-1:0];
                  dm_wd = vs_ff;
               end
               KIND_START: begin
                  state_in = S_CLEAR;
                  pc_in    = 15'd0;
                  npc_in   = 15'd0;
                  hl_we    = 1'b1;
                  hi_in    = 32'd0;
                  lo_in    = 32'd0;
                  halted_in = (plen == 17'd0);
                  st_in    = (plen == 17'd0) ? ST_END : ST_OK;
               end
               KIND_EXEC: begin
                  if (halted_ff || {2'b0, pc_ff} >= plen) begin
                     halted_in = 1'b1;
                     st_in     = ST_END;
                  end else begin
                     state_in = S_EXEC;
                  end
               end
               default: begin
               end
            endcase
         end
         S_EXEC: begin
            npc_in   = pc_ff + 15'd1;
            state_in = S_OUT;
            case (op)
               OP_SPECIAL: begin
                  case (fn)
                     FN_ADDU: begin wv_in = 1'b1; wr_in = rd; wval_in = vs_ff + vt_ff; end
                     FN_SUBU: begin wv_in = 1'b1; wr_in = rd; wval_in = vs_ff - vt_ff; end
                     FN_AND:  begin wv_in = 1'b1; wr_in = rd; wval_in = vs_ff & vt_ff; end
                     FN_OR:   begin wv_in = 1'b1; wr_in = rd; wval_in = vs_ff | vt_ff; end
                     FN_SLT:  begin
                        wv_in = 1'b1; wr_in = rd;
                        wval_in = {31'd0, $signed(vs_ff) < $signed(vt_ff)};
                     end
                     FN_MFHI: begin wv_in = 1'b1; wr_in = rd; wval_in = hi_ff; end
                     FN_MFLO: begin wv_in = 1'b1; wr_in = rd; wval_in = lo_ff; end
                     FN_MULT: begin md_req.start = 1'b1; state_in = S_MD; end
                     FN_DIV: begin
                        if (vt_ff == 32'd0) st_in = ST_DIV0;
                        else begin md_req.start = 1'b1; state_in = S_MD; end
                     end
                     FN_SYSCALL: begin
                        if (v0_ff == 32'd10) st_in = ST_EXIT;
                        else if (v0_ff == 32'd5) begin
                           wv_in = 1'b1; wr_in = REG_V0; wval_in = rv_ff;
                        end else if (v0_ff == 32'd1) begin
                           pv_in = 1'b1; pval_in = a0_ff;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
               OP_ADDIU: begin wv_in = 1'b1; wr_in = rt; wval_in = vs_ff + simm; end
               OP_BEQ, OP_BNE: begin
                  if ((op == OP_BEQ) == (vs_ff == vt_ff)) begin
                     jump   = 1'b1;
                     target = {3'd0, pc_ff} + simm[17:0];
                  end
               end
               OP_J: begin
                  jump = 1'b1;
                  // any target beyond 17 bits is illegal; fold into bit 17
                  target = {(|ins_ff[25:17]), ins_ff[16:0]};
               end
               OP_LW, OP_SW: begin
                  if (ins_ff[15] || {5'd0, ins_ff[15:0]} >= {10'd0, dlen}) st_in = ST_DATA;
                  else if (op == OP_LW) state_in = S_LOAD;
                  else dm_we = 1'b1;
               end
               default: begin
               end
            endcase
            if (jump) begin
               if (target[17] || target > {1'b0, plen}) st_in = ST_TARGET;
               else npc_in = target[14:0];
            end
         end
         S_MD: begin
            if (md_rsp.done) begin
               hl_we    = 1'b1;
               state_in = S_OUT;
            end
         end
         S_LOAD: begin
            wv_in    = 1'b1;
            wr_in    = rt;
            wval_in  = dmem_q_ff;
            state_in = S_OUT;
         end
         S_CLEAR: begin
            rf_we = 1'b1;
            rf_wa = clr_ff;
            rf_wd = (clr_ff == REG_GP) ? {16'd0, icount_ff} : 32'd0;
            if (clr_ff == 5'd31) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // commit: pc/halt update and register write on leaving an execute path
   logic commit;
   assign commit = (state_in == S_OUT) && (state_ff == S_EXEC || state_ff == S_MD
                   || state_ff == S_LOAD) && (kind_ff == KIND_EXEC);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         icount_ff <= 16'd0;
         dcount_ff <= 11'd0;
         pc_ff     <= 15'd0;
         halted_ff <= 1'b0;
         hi_ff     <= 32'd0;
         lo_ff     <= 32'd0;
         clr_ff    <= 5'd0;
         for (int i = 0; i < 32; i++) regs_ff[i] <= 32'd0;
      end else begin
         state_ff  <= state_in;
         pc_ff     <= pc_in;
         halted_ff <= halted_in;
         if (csr_psel && csr_penable && csr_pwrite) begin
            if (csr_paddr[2] == CSR_INSTR_COUNT) icount_ff <= csr_pwdata[15:0];
            else dcount_ff <= csr_pwdata[10:0];
         end
         if (hl_we) begin
            hi_ff <= hi_in;
            lo_ff <= lo_in;
         end
         clr_ff <= (state_ff == S_CLEAR) ? clr_ff + 5'd1 : 5'd0;
         if (rf_we) regs_ff[rf_wa] <= rf_wd;
         if (commit) begin
            if (st_in != ST_OK) begin
               halted_ff <= 1'b1;
            end else begin
               pc_ff <= npc_in;
               if ({2'b0, npc_in} >= plen || npc_in == 15'd0 && plen == 17'(ProgramDepth)
                   && pc_ff == 15'(ProgramDepth - 1)) halted_ff <= 1'b1;
            end
            if (wv_in && wr_in != 5'd0) regs_ff[wr_in] <= wval_in;
         end
      end
   end

   // end-of-program status and write masking are settled on the way out
   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && req_tvalid) begin
         kind_ff <= req_tuser;
         ins_ff  <= req_tdata[31:0];
         rv_ff   <= (req_tuser == KIND_LOAD) ? {22'd0, req_tdata[41:32]} : req_tdata[105:74];
         vs_ff   <= (req_tuser == KIND_LOAD) ? req_tdata[73:42] : regs_ff[req_tdata[25:21]];
         vt_ff   <= regs_ff[req_tdata[20:16]];
         v0_ff   <= regs_ff[REG_V0];
         a0_ff   <= regs_ff[REG_A0];
      end
      if (dm_we) dmem[dm_wa] <= dm_wd;
      dmem_q_ff <= dmem[ins_ff[DataAw-1:0]];
      if (state_ff == S_EXEC && st_in != ST_OK) npc_ff <= pc_ff;
      else npc_ff <= npc_in;
      if (commit && st_in == ST_OK && ({2'b0, npc_in} >= plen
          || npc_in == 15'd0 && plen == 17'(ProgramDepth) && pc_ff == 15'(ProgramDepth - 1)))
         st_ff <= ST_END;
      else st_ff <= st_in;
      if (wv_in && wr_in == 5'd0) begin
         wv_ff <= 1'b0; wr_ff <= 5'd0; wval_ff <= 32'd0;
      end else begin
         wv_ff <= wv_in; wr_ff <= wr_in; wval_ff <= wval_in;
      end
      pv_ff   <= pv_in;
      pval_ff <= pval_in;
   end

   `MSE_ASSERT_IMP(a_zero_reg, clock, reset, regs_ff[0] == 32'd0, "register zero changed")
   `MSE_ASSERT_IMP(a_no_accept_busy, clock, reset, !(req_tready && rsp_tvalid), "ready while busy")
   `MSE_ASSERT_IMP(a_out_holds, clock, reset,
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "result dropped")
   `MSE_ASSERT_IMP(a_md_only_in_md, clock, reset,
      md_rsp.done |-> state_ff == S_MD, "muldiv done outside wait")
endmodule
